>>> hdl/icpa_pkg.sv
`timescale 1ns / 1ps

package icpa_pkg;

  localparam int STORE_DEPTH = 16;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int LEN_W       = 5;
  localparam int CHAN_W      = 3;
  localparam int CMD_W       = 2;
  localparam int DATA_W      = 32;
  localparam int SUM_W       = DATA_W + $clog2(STORE_DEPTH);
  localparam int DCNT_W      = $clog2(SUM_W);
  localparam int CFG_W       = 5;

  localparam logic [DATA_W-1:0] COUNTER_TOP   = 32'hFFFF_FFFE;
  localparam logic [CHAN_W-1:0] CHANNEL_COUNT = 3'd4;
  localparam logic [LEN_W-1:0]  LENGTH_MAX    = LEN_W'(STORE_DEPTH);

  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CAPTURE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

  localparam logic CFG_FIFO_LENGTH      = 1'b0;
  localparam logic CFG_SELECTED_CHANNEL = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CHAN_W-1:0] event_channel;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0] last_capture;
    logic [DATA_W-1:0] average;
    logic              captured;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic exec;
    logic sum_clr;
    logic sum_acc;
    logic div_init;
    logic div_step;
    logic load_avg;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_query;
    logic sum_last;
    logic div_last;
    logic out_free;
  } ctrl_status_t;

endpackage

>>> hdl/icpa_ctrl.sv
`timescale 1ns / 1ps

module icpa_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  icpa_pkg::ctrl_status_t status,
  output icpa_pkg::ctrl_cmd_t    cmd
);

  icpa_pkg::state_t state;
  icpa_pkg::state_t state_next;
  logic             take;

  assign take = (state == icpa_pkg::ST_IDLE) && status.out_free && in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= icpa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      icpa_pkg::ST_IDLE: begin
        if (take && status.is_query) begin
          state_next = icpa_pkg::ST_SUM;
        end
      end
      icpa_pkg::ST_SUM: begin
        if (status.sum_last) begin
          state_next = icpa_pkg::ST_DIV_LOAD;
        end
      end
      icpa_pkg::ST_DIV_LOAD: begin
        state_next = icpa_pkg::ST_DIV;
      end
      icpa_pkg::ST_DIV: begin
        if (status.div_last) begin
          state_next = icpa_pkg::ST_DONE;
        end
      end
      icpa_pkg::ST_DONE: begin
        if (status.out_free) begin
          state_next = icpa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = icpa_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      icpa_pkg::ST_IDLE: begin
        in_ready    = status.out_free;
        cmd.exec    = take && !status.is_query;
        cmd.sum_clr = take && status.is_query;
      end
      icpa_pkg::ST_SUM: begin
        cmd.sum_acc = 1'b1;
      end
      icpa_pkg::ST_DIV_LOAD: begin
        cmd.div_init = 1'b1;
      end
      icpa_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      icpa_pkg::ST_DONE: begin
        cmd.load_avg = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> hdl/icpa_dp.sv
`timescale 1ns / 1ps

module icpa_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [icpa_pkg::CFG_W-1:0]      cfg_data,
  input  icpa_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output icpa_pkg::out_t                  out_data,
  input  icpa_pkg::ctrl_cmd_t             cmd,
  output icpa_pkg::ctrl_status_t          status
);

  localparam int IDX_W  = icpa_pkg::IDX_W;
  localparam int LEN_W  = icpa_pkg::LEN_W;
  localparam int CHAN_W = icpa_pkg::CHAN_W;
  localparam int DATA_W = icpa_pkg::DATA_W;
  localparam int SUM_W  = icpa_pkg::SUM_W;
  localparam int DCNT_W = icpa_pkg::DCNT_W;

  logic [LEN_W-1:0]  fifo_length;
  logic [CHAN_W-1:0] selected_channel;

  logic [DATA_W-1:0] tick_count;
  logic [DATA_W-1:0] latched_value;
  logic [IDX_W-1:0]  write_index;
  logic [DATA_W-1:0] store [icpa_pkg::STORE_DEPTH];
  logic [icpa_pkg::STORE_DEPTH-1:0] store_valid;

  logic [IDX_W-1:0]  sum_idx;
  logic [SUM_W-1:0]  sum_acc;
  logic [SUM_W-1:0]  quot;
  logic [LEN_W-1:0]  rem;
  logic [DCNT_W-1:0] div_cnt;

  logic              hit;
  logic [LEN_W-1:0]  slot_inc;
  logic [IDX_W-1:0]  write_index_next;
  logic [DATA_W-1:0] tick_next;
  logic [LEN_W-1:0]  len_m1;
  logic [DATA_W-1:0] entry;
  logic [LEN_W:0]    trial;
  logic              trial_ge;

  // configuration, clamped to the legal range
  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_length      <= icpa_pkg::LENGTH_MAX;
      selected_channel <= CHAN_W'(1);
    end else if (cfg_we) begin
      if (cfg_index == icpa_pkg::CFG_FIFO_LENGTH) begin
        if (cfg_data[LEN_W-1:0] == '0) begin
          fifo_length <= LEN_W'(1);
        end else if (cfg_data[LEN_W-1:0] > icpa_pkg::LENGTH_MAX) begin
          fifo_length <= icpa_pkg::LENGTH_MAX;
        end else begin
          fifo_length <= cfg_data[LEN_W-1:0];
        end
      end else begin
        if (cfg_data[CHAN_W-1:0] == '0) begin
          selected_channel <= CHAN_W'(1);
        end else if (cfg_data[CHAN_W-1:0] > icpa_pkg::CHANNEL_COUNT) begin
          selected_channel <= icpa_pkg::CHANNEL_COUNT;
        end else begin
          selected_channel <= cfg_data[CHAN_W-1:0];
        end
      end
    end
  end

  assign hit      = (in_data.command == icpa_pkg::CMD_CAPTURE) &&
                    (in_data.event_channel == selected_channel);
  assign slot_inc = LEN_W'(write_index) + LEN_W'(1);
  assign write_index_next = (slot_inc >= fifo_length) ? '0 : slot_inc[IDX_W-1:0];
  assign tick_next = (tick_count >= icpa_pkg::COUNTER_TOP) ? '0 : tick_count + DATA_W'(1);

  // counter, latch and ring write
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= '0;
      latched_value <= '0;
      write_index   <= '0;
      store_valid   <= '0;
    end else if (cmd.exec) begin
      if (in_data.command == icpa_pkg::CMD_TICK) begin
        tick_count <= tick_next;
      end else if (hit) begin
        latched_value            <= tick_count;
        tick_count               <= '0;
        write_index              <= write_index_next;
        store_valid[write_index] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && hit) begin
      store[write_index] <= tick_count;
    end
  end

  // walk the first fifo_length entries, one per cycle
  assign len_m1 = fifo_length - LEN_W'(1);
  assign entry  = store_valid[sum_idx] ? store[sum_idx] : '0;

  always_ff @(posedge clk) begin
    if (cmd.sum_clr) begin
      sum_idx <= '0;
      sum_acc <= '0;
    end else if (cmd.sum_acc) begin
      sum_idx <= sum_idx + IDX_W'(1);
      sum_acc <= sum_acc + SUM_W'(entry);
    end
  end

  // restoring divider, one quotient bit per cycle
  assign trial    = {rem, quot[SUM_W-1]};
  assign trial_ge = trial >= (LEN_W + 1)'(fifo_length);

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quot    <= sum_acc;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= trial_ge ? LEN_W'(trial - (LEN_W + 1)'(fifo_length)) : trial[LEN_W-1:0];
      quot    <= {quot[SUM_W-2:0], trial_ge};
      div_cnt <= div_cnt + DCNT_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec || cmd.load_avg) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_data.last_capture <= hit ? tick_count : latched_value;
      out_data.average      <= '0;
      out_data.captured     <= hit;
    end else if (cmd.load_avg) begin
      out_data.last_capture <= latched_value;
      out_data.average      <= quot[DATA_W-1:0];
      out_data.captured     <= 1'b0;
    end
  end

  assign status.is_query = (in_data.command == icpa_pkg::CMD_QUERY);
  assign status.sum_last = (sum_idx == len_m1[IDX_W-1:0]);
  assign status.div_last = (div_cnt == DCNT_W'(SUM_W - 1));
  assign status.out_free = !out_valid || out_ready;

endmodule

>>> hdl/input_capture_period_averager_top.sv
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// in        in_valid / in_ready    in_data   (command, event_channel)
// out       out_valid / out_ready  out_data  (last_capture, average, captured)
// cfg       cfg_we                 cfg_index, cfg_data
//
// For tick, capture and unused commands the result is registered at the edge
// that accepts the transaction.
// A query sums the first fifo_length entries in a walk, then divides the sum
// by fifo_length in the 36-bit restoring divider.
// Reset (rst, synchronous) clears the counter, latch, index and entry valid bits.
// in_ready drops while a query runs or while the result register is full and
// out_ready is low.

module input_capture_period_averager_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  icpa_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output icpa_pkg::out_t             out_data,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [icpa_pkg::CFG_W-1:0] cfg_data
);

  icpa_pkg::ctrl_cmd_t    cmd;
  icpa_pkg::ctrl_status_t status;

  icpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  icpa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

  // a query holds off further transactions while it runs
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.command == icpa_pkg::CMD_QUERY) |=> !in_ready)
    else $error("input accepted during a running query");

  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.command != icpa_pkg::CMD_QUERY) |=> out_valid)
    else $error("single-cycle transaction produced no result");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.captured |-> (out_data.average == '0))
    else $error("capture result carries a nonzero average");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam logic [icpa_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 60;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 96;

  typedef struct {
    bit                          is_cfg;
    logic                        reg_sel;
    logic [icpa_pkg::CFG_W-1:0]  reg_val;
    icpa_pkg::in_t               item;
    bit                          typed;
    icpa_pkg::out_t              want;
  } plan_row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  icpa_pkg::in_t              in_data = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  icpa_pkg::out_t             out_data;
  logic                       cfg_we = 1'b0;
  logic                       cfg_index = 1'b0;
  logic [icpa_pkg::CFG_W-1:0] cfg_data = '0;

  // predictor state
  logic [icpa_pkg::DATA_W-1:0] tick_cnt = '0;
  logic [icpa_pkg::DATA_W-1:0] latched = '0;
  logic [icpa_pkg::DATA_W-1:0] ring_entries [icpa_pkg::STORE_DEPTH];
  int                          wr_idx = 0;
  logic [icpa_pkg::LEN_W-1:0]  ring_len = icpa_pkg::LENGTH_MAX;
  logic [icpa_pkg::CHAN_W-1:0] sel_chan = 3'd1;

  icpa_pkg::out_t expected_results [$];
  int   mismatch_count = 0;
  int   idle_cycles = 0;
  bit   quiet = 1'b0;
  bit   hold_go = 1'b0;

  input_capture_period_averager_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic icpa_pkg::out_t predict_capture_step(icpa_pkg::in_t it);
    icpa_pkg::out_t             r;
    logic [icpa_pkg::SUM_W-1:0] sum;
    int                         slot;
    r = '0;
    case (it.command)
      icpa_pkg::CMD_TICK: begin
        tick_cnt = (tick_cnt >= icpa_pkg::COUNTER_TOP) ? '0 :
                   tick_cnt + icpa_pkg::DATA_W'(1);
      end
      icpa_pkg::CMD_CAPTURE: begin
        if (it.event_channel == sel_chan) begin
          latched = tick_cnt;
          tick_cnt = '0;
          slot = (wr_idx >= icpa_pkg::STORE_DEPTH) ? 0 : wr_idx;
          ring_entries[slot] = latched;
          slot++;
          wr_idx = (slot >= ring_len) ? 0 : slot;
          r.captured = 1'b1;
        end
      end
      icpa_pkg::CMD_QUERY: begin
        sum = '0;
        for (int i = 0; i < ring_len; i++) sum += icpa_pkg::SUM_W'(ring_entries[i]);
        r.average = icpa_pkg::DATA_W'(sum / icpa_pkg::SUM_W'(ring_len));
      end
      default: ;  // unused command: counter holds
    endcase
    r.last_capture = latched;
    return r;
  endfunction

  function automatic void apply_register(logic sel, logic [icpa_pkg::CFG_W-1:0] v);
    logic [icpa_pkg::CHAN_W-1:0] c;
    if (sel == icpa_pkg::CFG_FIFO_LENGTH) begin
      if (v == 0) ring_len = icpa_pkg::LEN_W'(1);
      else if (v > icpa_pkg::LENGTH_MAX) ring_len = icpa_pkg::LENGTH_MAX;
      else ring_len = icpa_pkg::LEN_W'(v);
    end else begin
      c = v[icpa_pkg::CHAN_W-1:0];
      if (c == 0) sel_chan = icpa_pkg::CHAN_W'(1);
      else if (c > icpa_pkg::CHANNEL_COUNT) sel_chan = icpa_pkg::CHANNEL_COUNT;
      else sel_chan = c;
    end
  endfunction

  function automatic void check_result(icpa_pkg::out_t got);
    icpa_pkg::out_t exp_r;
    if (expected_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected result: last_capture %h average %h captured %b",
                 got.last_capture, got.average, got.captured);
      return;
    end
    exp_r = expected_results.pop_front();
    if (got.last_capture !== exp_r.last_capture || got.average !== exp_r.average ||
        got.captured !== exp_r.captured) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display({"mismatch: last_capture exp %h got %h, average exp %h got %h, ",
                  "captured exp %b got %b"},
                 exp_r.last_capture, got.last_capture, exp_r.average, got.average,
                 exp_r.captured, got.captured);
    end
  endfunction

  function automatic plan_row_t row_item(logic [icpa_pkg::CMD_W-1:0] cmd,
                                         logic [icpa_pkg::CHAN_W-1:0] ch);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.reg_sel = 1'b0;
    r.reg_val = '0;
    r.item.command = cmd;
    r.item.event_channel = ch;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic plan_row_t row_typed(logic [icpa_pkg::CMD_W-1:0] cmd,
                                          logic [icpa_pkg::CHAN_W-1:0] ch,
                                          logic [icpa_pkg::DATA_W-1:0] last,
                                          logic [icpa_pkg::DATA_W-1:0] avg,
                                          logic cap);
    plan_row_t r;
    r = row_item(cmd, ch);
    r.typed = 1'b1;
    r.want.last_capture = last;
    r.want.average = avg;
    r.want.captured = cap;
    return r;
  endfunction

  function automatic plan_row_t row_cfg(logic sel, logic [icpa_pkg::CFG_W-1:0] v);
    plan_row_t r;
    r = row_item(icpa_pkg::CMD_TICK, '0);
    r.is_cfg = 1'b1;
    r.reg_sel = sel;
    r.reg_val = v;
    return r;
  endfunction

  task automatic send_item(input icpa_pkg::in_t it, input bit typed,
                           input icpa_pkg::out_t want);
    icpa_pkg::out_t p;
    p = predict_capture_step(it);
    expected_results.push_back(typed ? want : p);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // Registers change only once every pending result has drained.
  task automatic write_register(input logic sel, input logic [icpa_pkg::CFG_W-1:0] v);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_register(sel, v);
  endtask

  initial begin : result_sink
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) check_result(out_data);
      if (hold_go && !hold_done) begin
        // hold off long enough for the block to back up into its input
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    plan_row_t                   plan [$];
    logic [icpa_pkg::CFG_W-1:0]  len_picks [6];
    logic [icpa_pkg::CFG_W-1:0]  chan_picks [6];
    logic [icpa_pkg::CFG_W-1:0]  len_v;
    logic [icpa_pkg::CFG_W-1:0]  chan_v;
    icpa_pkg::in_t               it;
    int                          r;

    foreach (ring_entries[i]) ring_entries[i] = '0;
    len_picks  = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd15};
    chan_picks = '{5'd4, 5'd1, 5'd0, 5'd7, 5'd2, 5'd3};

    // after reset: length 16, channel 1, empty store
    plan.push_back(row_typed(icpa_pkg::CMD_QUERY,   3'd0, 32'd0, 32'd0, 1'b0));
    plan.push_back(row_typed(icpa_pkg::CMD_CAPTURE, 3'd1, 32'd0, 32'd0, 1'b1));
    plan.push_back(row_typed(icpa_pkg::CMD_TICK,    3'd0, 32'd0, 32'd0, 1'b0));
    plan.push_back(row_typed(icpa_pkg::CMD_TICK,    3'd7, 32'd0, 32'd0, 1'b0));
    plan.push_back(row_typed(icpa_pkg::CMD_TICK,    3'd3, 32'd0, 32'd0, 1'b0));
    plan.push_back(row_typed(CMD_UNUSED,            3'd5, 32'd0, 32'd0, 1'b0));
    plan.push_back(row_typed(icpa_pkg::CMD_CAPTURE, 3'd2, 32'd0, 32'd0, 1'b0));
    plan.push_back(row_typed(icpa_pkg::CMD_CAPTURE, 3'd0, 32'd0, 32'd0, 1'b0));
    plan.push_back(row_typed(icpa_pkg::CMD_CAPTURE, 3'd7, 32'd0, 32'd0, 1'b0));
    plan.push_back(row_typed(icpa_pkg::CMD_CAPTURE, 3'd1, 32'd3, 32'd0, 1'b1));
    plan.push_back(row_item(icpa_pkg::CMD_TICK, 3'd1));
    plan.push_back(row_item(icpa_pkg::CMD_CAPTURE, 3'd1));
    // shrink the ring below the write index
    plan.push_back(row_cfg(icpa_pkg::CFG_FIFO_LENGTH, 5'd2));
    plan.push_back(row_item(icpa_pkg::CMD_CAPTURE, 3'd1));
    plan.push_back(row_item(icpa_pkg::CMD_QUERY, 3'd4));
    plan.push_back(row_cfg(icpa_pkg::CFG_FIFO_LENGTH, 5'd0));
    plan.push_back(row_cfg(icpa_pkg::CFG_SELECTED_CHANNEL, 5'd0));
    plan.push_back(row_item(icpa_pkg::CMD_TICK, 3'd2));
    plan.push_back(row_item(icpa_pkg::CMD_CAPTURE, 3'd1));
    plan.push_back(row_item(icpa_pkg::CMD_QUERY, 3'd6));
    plan.push_back(row_cfg(icpa_pkg::CFG_FIFO_LENGTH, 5'd31));
    plan.push_back(row_cfg(icpa_pkg::CFG_SELECTED_CHANNEL, 5'd7));
    plan.push_back(row_item(icpa_pkg::CMD_TICK, 3'd0));
    plan.push_back(row_item(icpa_pkg::CMD_CAPTURE, 3'd4));
    plan.push_back(row_item(icpa_pkg::CMD_CAPTURE, 3'd1));
    plan.push_back(row_item(icpa_pkg::CMD_QUERY, 3'd0));
    plan.push_back(row_cfg(icpa_pkg::CFG_SELECTED_CHANNEL, 5'd13));
    plan.push_back(row_item(icpa_pkg::CMD_CAPTURE, 3'd4));
    plan.push_back(row_cfg(icpa_pkg::CFG_SELECTED_CHANNEL, 5'd2));
    plan.push_back(row_item(icpa_pkg::CMD_CAPTURE, 3'd2));
    plan.push_back(row_item(icpa_pkg::CMD_QUERY, 3'd2));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[k]) begin
      if (plan[k].is_cfg) write_register(plan[k].reg_sel, plan[k].reg_val);
      else send_item(plan[k].item, plan[k].typed, plan[k].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1) quiet = 1'b1;
      len_v  = (ph < 6) ? len_picks[ph]  : icpa_pkg::CFG_W'($urandom_range(0, 31));
      chan_v = (ph < 6) ? chan_picks[ph] : icpa_pkg::CFG_W'($urandom_range(0, 31));
      write_register(icpa_pkg::CFG_FIFO_LENGTH, len_v);
      write_register(icpa_pkg::CFG_SELECTED_CHANNEL, chan_v);
      // start the long hold while items keep coming
      if (ph == 2) hold_go = 1'b1;
      repeat (PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        it.event_channel = icpa_pkg::CHAN_W'($urandom_range(0, 7));
        if (r < 55) begin
          it.command = icpa_pkg::CMD_TICK;
        end else if (r < 75) begin
          it.command = icpa_pkg::CMD_CAPTURE;
          it.event_channel = sel_chan;
        end else if (r < 85) begin
          it.command = icpa_pkg::CMD_CAPTURE;
        end else if (r < 95) begin
          it.command = icpa_pkg::CMD_QUERY;
        end else begin
          it.command = CMD_UNUSED;
        end
        send_item(it, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> input_capture_period_averager_top.f
hdl/icpa_pkg.sv
hdl/icpa_ctrl.sv
hdl/icpa_dp.sv
hdl/input_capture_period_averager_top.sv
bench/testbench.sv
